[rtl/core/header_length_xor_frame_parser_core_macros.svh]
// assertion macros shared by the frame parser modules
`ifndef HEADER_LENGTH_XOR_FRAME_PARSER_CORE_MACROS_SVH
`define HEADER_LENGTH_XOR_FRAME_PARSER_CORE_MACROS_SVH

// checked only outside reset
`define HLX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HLX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/hlx_pkg.sv]
// shared constants and types of the frame parser
`timescale 1ns / 1ps
package hlx_pkg;

	// frame characters
	localparam logic [7:0] CH_U       = 8'h55;
	localparam logic [7:0] CH_N       = 8'h4E;
	localparam logic [7:0] CH_E       = 8'h45;
	localparam logic [7:0] CH_R       = 8'h52;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// xor of header and token bytes, count is folded in later
	localparam logic [7:0] XOR_SEED = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

	// parser state codes
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_HDR_N   = 4'd1;
	localparam logic [3:0] ST_HDR_E   = 4'd2;
	localparam logic [3:0] ST_HDR_R   = 4'd3;
	localparam logic [3:0] ST_COUNT   = 4'd4;
	localparam logic [3:0] ST_TOKEN   = 4'd5;
	localparam logic [3:0] ST_PAYLOAD = 4'd6;
	localparam logic [3:0] ST_DEBUG   = 4'd7;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;
	localparam logic [1:0] KIND_DEBUG   = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] value;
		logic [7:0] position;
		logic       last;
	} result_t;

	// where an idle parser goes on a given byte
	function automatic logic [3:0] idle_next(input logic [7:0] b);
		logic [3:0] st;
		st = ST_IDLE;
		if (b == CH_U) begin
			st = ST_HDR_N;
		end else if (b == CH_PLUS) begin
			st = ST_DEBUG;
		end
		return st;
	endfunction

endpackage

[rtl/core/hlx_parse.sv]
// parser state machine: per-byte state update and result decode
`timescale 1ns / 1ps
`include "header_length_xor_frame_parser_core_macros.svh"
module hlx_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        rx_byte,
	output hlx_pkg::result_t  res
);
	import hlx_pkg::*;

	logic [3:0] state_q, state_d;
	logic [7:0] count_q, count_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] count_dec;
	logic [3:0] idle_st;

	assign count_dec = count_q - 8'd1;
	assign idle_st   = idle_next(rx_byte);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		xor_d   = xor_q;
		pos_d   = pos_q;
		res     = '0;
		case (state_q)
			ST_IDLE: begin
				state_d = idle_st;
				if (rx_byte == CH_U) begin
					xor_d = 8'd0;
				end
			end
			ST_HDR_N, ST_HDR_E, ST_HDR_R: begin
				if ((state_q == ST_HDR_N && rx_byte == CH_N) ||
				    (state_q == ST_HDR_E && rx_byte == CH_E) ||
				    (state_q == ST_HDR_R && rx_byte == CH_R)) begin
					state_d = state_q + 4'd1;
				end else begin
					state_d = idle_st;
					if (rx_byte == CH_U) begin
						xor_d = 8'd0;
					end
				end
			end
			ST_COUNT: begin
				count_d = rx_byte;
				state_d = ST_TOKEN;
			end
			ST_TOKEN: begin
				if (rx_byte == CH_COLON) begin
					state_d      = ST_PAYLOAD;
					xor_d        = XOR_SEED ^ count_q;
					pos_d        = 8'd1;
					res.valid    = 1'b1;
					res.kind     = KIND_PAYLOAD;
					res.value    = count_q;
					res.position = 8'd0;
					res.last     = 1'b0;
				end else begin
					state_d = idle_st;
					if (rx_byte == CH_U) begin
						xor_d = 8'd0;
					end
				end
			end
			ST_PAYLOAD: begin
				count_d = count_dec;
				if (count_q > 8'd1) begin
					res.valid    = 1'b1;
					res.kind     = KIND_PAYLOAD;
					res.value    = rx_byte;
					res.position = pos_q;
					pos_d        = pos_q + 8'd1;
					xor_d        = xor_q ^ rx_byte;
				end
				// count of one: this byte is the checksum
				if (count_dec == 8'd0) begin
					state_d      = ST_IDLE;
					res.valid    = 1'b1;
					res.kind     = (xor_q == rx_byte) ? KIND_ACCEPT : KIND_BAD;
					res.value    = rx_byte;
					res.position = 8'd0;
					res.last     = 1'b1;
				end
			end
			ST_DEBUG: begin
				res.valid = 1'b1;
				res.kind  = KIND_DEBUG;
				res.value = rx_byte;
				if (rx_byte == CH_NEWLINE) begin
					state_d  = ST_IDLE;
					res.last = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= 8'd0;
			xor_q   <= 8'd0;
			pos_q   <= 8'd0;
		end else if (step_en) begin
			state_q <= state_d;
			count_q <= count_d;
			xor_q   <= xor_d;
			pos_q   <= pos_d;
		end
	end

	`HLX_ASSERT(a_idle_silent, (state_q == ST_IDLE) |-> !res.valid, "idle byte gave a result")
	`HLX_ASSERT(a_token_emits_count, (state_q == ST_TOKEN && rx_byte == CH_COLON) |-> (res.valid && res.value == count_q && res.position == 8'd0), "count byte not emitted on token")
	`HLX_ASSERT(a_status_last, (res.valid && (res.kind == KIND_ACCEPT || res.kind == KIND_BAD)) |-> (res.last && state_d == ST_IDLE), "status without last or idle return")
	`HLX_ASSERT(a_step_state, (!step_en && state_q != ST_DEBUG) |=> $stable(state_q) || $past(state_q) == ST_DEBUG, "state moved without a step")

endmodule

[rtl/core/header_length_xor_frame_parser_core.sv]
// an accepted request is held in the input register and decoded; its result is registered onto m_*
// throughput: one byte per cycle, sustained, as long as m_tready stays high
// the input register and output register let a new byte in while a result waits
// bytes that give no result (header, count, ignored idle bytes) produce no output
// reset: arst_n low clears the parser to idle, count, xor and position to zero
// and empties both the input and the output register
`timescale 1ns / 1ps
`include "header_length_xor_frame_parser_core_macros.svh"
module header_length_xor_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] value, [15:8] position
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last
);
	import hlx_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  value_q;
	logic [7:0]  position_q;
	logic        last_q;

	logic    advance;   // output register free or being drained this cycle
	logic    step;      // the held byte is processed this cycle
	result_t res;

	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// input stage: take a request whenever the input register is empty or the held byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// state update and result decode
	hlx_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q     <= res.kind;
			value_q    <= res.value;
			position_q <= res.position;
			last_q     <= res.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {position_q, value_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	// stalls only come from a full output register that is not drained
	`HLX_ASSERT_ALWAYS(a_stall_cause, !s_tready |-> (valid_s1 && out_valid_q && !m_tready), "input stalled without output backpressure")
	`HLX_ASSERT(a_result_lands, (step && res.valid) |=> m_tvalid, "decoded result not registered")
	`HLX_ASSERT(a_no_phantom, (advance && !(step && res.valid)) |=> !m_tvalid, "output valid without a decoded result")
	`HLX_ASSERT(a_position_zero, (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata[15:8] == 8'd0), "nonzero position on a non-payload result")

endmodule
